// ----- rtl/mbc_pkg.sv -----
`timescale 1ns / 1ps
package mbc_pkg;
  localparam int ENTRIES = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int BLOCK_SHIFT = 12;
  localparam int OFF_W = 40;
  localparam int TAG_W = OFF_W - BLOCK_SHIFT;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_READ  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_FLUSH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_MISS, ST_FLUSH, ST_CLEAR
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic hit_upd;   // move hit slot to head, mark dirty on write
    logic miss_upd;  // evict if full, then insert unless a read past end
    logic flush_pos; // hold the dirty entry at the walk position, emit the one held before
    logic flush_adv; // step the walk position
    logic clear;     // invalidate everything
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic flush_done;  // walk position has reached the valid count
  } dp_stat_t;
endpackage

// ----- rtl/mbc_ctrl.sv -----
`timescale 1ns / 1ps
module mbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mbc_pkg::cmd_t      in_command,
  input  mbc_pkg::dp_stat_t  stat,
  output logic               busy,
  output mbc_pkg::dp_cmd_t   cmd
);
  import mbc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_command == CMD_FLUSH) state_nxt = ST_FLUSH;
          else if (in_command == CMD_READ || in_command == CMD_WRITE)
            state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat.hit) begin
          cmd.hit_upd = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        cmd.miss_upd = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (stat.flush_done) begin
          state_nxt = ST_CLEAR;
        end else begin
          cmd.flush_pos = 1'b1;
          cmd.flush_adv = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.hit_upd && cmd.miss_upd))
    else $error("hit and miss update together");
  a_clear_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> $past(state_r) == ST_FLUSH)
    else $error("clear without flush walk");
  a_idle_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.miss_upd |=> state_r == ST_IDLE)
    else $error("miss did not return to idle");
endmodule

// ----- rtl/mbc_dp.sv -----
`timescale 1ns / 1ps
module mbc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbc_pkg::dp_cmd_t           cmd,
  input  mbc_pkg::cmd_t              in_command,
  input  logic [mbc_pkg::OFF_W-1:0]  in_file_offset,
  input  logic                       in_past_end,
  input  logic [mbc_pkg::CNT_W-1:0]  capacity,
  output mbc_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [mbc_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_fill,
  output logic                       out_inserted,
  output logic                       out_writeback,
  output logic [mbc_pkg::TAG_W-1:0]  out_writeback_block,
  output logic [mbc_pkg::SLOT_W-1:0] out_writeback_slot,
  output logic                       out_last
);
  import mbc_pkg::*;

  logic [TAG_W-1:0]  tags_r [ENTRIES];
  logic [ENTRIES-1:0] dirty_r;
  logic [SLOT_W-1:0] order_r [ENTRIES];
  logic [CNT_W-1:0]  cnt_r;
  cmd_t              op_r;
  logic [TAG_W-1:0]  tag_r;
  logic              pe_r;
  logic [CNT_W-1:0]  fpos_r;
  logic              pend_v_r;
  logic [TAG_W-1:0]  pend_tag_r;
  logic [SLOT_W-1:0] pend_slot_r;

  // Lookup compare against the captured tag, used in the lookup cycle.
  logic              hit_c;
  logic [SLOT_W-1:0] hpos_c;
  always_comb begin
    hit_c = 1'b0;
    hpos_c = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      if (!hit_c && CNT_W'(p) < cnt_r && tags_r[order_r[p]] == tag_r) begin
        hit_c = 1'b1;
        hpos_c = SLOT_W'(p);
      end
    end
  end

  logic [CNT_W-1:0] cap_c;
  always_comb begin
    cap_c = capacity;
    if (cap_c == '0) cap_c = CNT_W'(1);
    if (cap_c > CNT_W'(ENTRIES)) cap_c = CNT_W'(ENTRIES);
  end

  logic              evict_c;
  logic [SLOT_W-1:0] head_c;
  logic [CNT_W-1:0]  cnt_ev_c;
  logic [SLOT_W-1:0] free_c;
  logic              ins_c;
  assign head_c = order_r[0];
  assign evict_c = (cnt_r >= cap_c) && (cnt_r != '0);
  assign cnt_ev_c = evict_c ? cnt_r - CNT_W'(1) : cnt_r;
  assign ins_c = !(op_r == CMD_READ && pe_r);
  // After an eviction the head slot rotates to position cnt-1, which is the new free slot.
  assign free_c = evict_c ? head_c : order_r[cnt_r[SLOT_W-1:0]];

  logic [SLOT_W-1:0] fslot_c;
  assign fslot_c = order_r[fpos_r[SLOT_W-1:0]];
  assign stat.hit = hit_c;
  assign stat.flush_done = (fpos_r >= cnt_r);

  logic [SLOT_W-1:0] hslot_c;
  assign hslot_c = order_r[hpos_c];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_command;
      tag_r <= in_file_offset[OFF_W-1:BLOCK_SHIFT];
      pe_r <= in_past_end;
    end
    if (cmd.miss_upd && ins_c) tags_r[free_c] <= tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
      cnt_r <= '0;
      fpos_r <= '0;
      for (int i = 0; i < ENTRIES; i++) order_r[i] <= SLOT_W'(i);
      out_valid <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.load) fpos_r <= '0;
      if (cmd.hit_upd) begin
        for (int i = 1; i < ENTRIES; i++)
          if (SLOT_W'(i) <= hpos_c) order_r[i] <= order_r[i-1];
        order_r[0] <= hslot_c;
        if (op_r == CMD_WRITE) dirty_r[hslot_c] <= 1'b1;
        out_valid <= 1'b1;
        out_hit <= 1'b1; out_slot <= hslot_c; out_fill <= 1'b0;
        out_inserted <= 1'b0; out_writeback <= 1'b0;
        out_writeback_block <= '0; out_writeback_slot <= '0; out_last <= 1'b1;
      end
      if (cmd.miss_upd) begin
        // Combined effect of eviction rotate and insert-at-head.
        if (ins_c) begin
          if (evict_c) begin
            // Evict removes head; insert brings head slot (now at cnt-1) back.
            order_r[0] <= head_c;
          end else begin
            for (int i = 1; i < ENTRIES; i++)
              if (CNT_W'(i) <= cnt_r) order_r[i] <= order_r[i-1];
            order_r[0] <= free_c;
          end
          cnt_r <= cnt_ev_c + CNT_W'(1);
          dirty_r[free_c] <= (op_r == CMD_WRITE);
        end else if (evict_c) begin
          for (int i = 0; i < ENTRIES - 1; i++)
            if (CNT_W'(i + 1) < cnt_r) order_r[i] <= order_r[i+1];
          order_r[cnt_ev_c[SLOT_W-1:0]] <= head_c;
          cnt_r <= cnt_ev_c;
          dirty_r[head_c] <= 1'b0;
        end
        out_valid <= 1'b1;
        out_hit <= 1'b0;
        out_slot <= ins_c ? free_c : '0;
        out_fill <= 1'b1;
        out_inserted <= ins_c;
        out_writeback <= evict_c && dirty_r[head_c];
        out_writeback_block <= (evict_c && dirty_r[head_c]) ? tags_r[head_c] : '0;
        out_writeback_slot <= (evict_c && dirty_r[head_c]) ? head_c : '0;
        out_last <= 1'b1;
      end
      // Flush: hold one dirty entry back so the final one can carry last.
      if (cmd.flush_adv) fpos_r <= fpos_r + CNT_W'(1);
      if (cmd.flush_pos && dirty_r[fslot_c]) begin
        if (pend_v_r) begin
          out_valid <= 1'b1;
          out_hit <= 1'b0; out_slot <= '0; out_fill <= 1'b0; out_inserted <= 1'b0;
          out_writeback <= 1'b1; out_writeback_block <= pend_tag_r;
          out_writeback_slot <= pend_slot_r; out_last <= 1'b0;
        end
        pend_v_r <= 1'b1;
        pend_tag_r <= tags_r[fslot_c];
        pend_slot_r <= fslot_c;
      end
      if (cmd.clear) begin
        if (pend_v_r) begin
          out_valid <= 1'b1;
          out_hit <= 1'b0; out_slot <= '0; out_fill <= 1'b0; out_inserted <= 1'b0;
          out_writeback <= 1'b1; out_writeback_block <= pend_tag_r;
          out_writeback_slot <= pend_slot_r; out_last <= 1'b1;
        end
        pend_v_r <= 1'b0;
        dirty_r <= '0;
        cnt_r <= '0;
        for (int i = 0; i < ENTRIES; i++) order_r[i] <= SLOT_W'(i);
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES))
    else $error("valid count above entries");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> cnt_r == '0 && dirty_r == '0)
    else $error("clear left entries");
  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit_upd |=> out_valid && out_hit && out_last)
    else $error("hit result missing");
endmodule

// ----- rtl/mru_block_cache.sv -----
`timescale 1ns / 1ps
// A hit's result is registered on the ports after the lookup state, a miss's after the lookup and miss states.
// The block is busy until an access or flush completes and takes no new request meanwhile; a flush walks the
// valid entries, one walk step per cycle, then clears, with one result per dirty block.
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module mru_block_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic [mbc_pkg::OFF_W-1:0]  in_file_offset,
  input  logic                       in_past_end,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [mbc_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_fill,
  output logic                       out_inserted,
  output logic                       out_writeback,
  output logic [mbc_pkg::TAG_W-1:0]  out_writeback_block,
  output logic [mbc_pkg::SLOT_W-1:0] out_writeback_slot,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mbc_pkg::CNT_W-1:0]  cfg_data
);
  import mbc_pkg::*;

  logic [CNT_W-1:0] capacity_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy_c;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= CNT_W'(ENTRIES);
    else if (cfg_valid) capacity_r <= cfg_data;
  end

  assign busy = busy_c;

  mbc_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_command(in_command), .stat, .busy(busy_c), .cmd
  );

  mbc_dp u_dp (
    .clk, .rst_n, .cmd, .in_command(in_command), .in_file_offset, .in_past_end,
    .capacity(capacity_r), .stat, .out_valid, .out_hit, .out_slot, .out_fill,
    .out_inserted, .out_writeback, .out_writeback_block, .out_writeback_slot,
    .out_last
  );
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import mbc_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [SLOT_W-1:0] slot;
    logic             fill;
    logic             inserted;
    logic             writeback;
    logic [TAG_W-1:0] wb_block;
    logic [SLOT_W-1:0] wb_slot;
    logic             last;
  } cache_res_t;

  // Tracks cache contents and the results each request should produce.
  class cache_scoreboard;
    logic [TAG_W-1:0] tags[ENTRIES];
    bit valid[ENTRIES];
    bit dirty[ENTRIES];
    int order[ENTRIES];
    int count;
    int cap_reg;
    cache_res_t pending[$];
    int mismatches;
    int checked;

    function void clear_all();
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] = 0;
        dirty[i] = 0;
        order[i] = i;
      end
      count = 0;
    endfunction

    function void set_capacity(int v);
      cap_reg = v & 31;
    endfunction

    function void move_to_head(int pos);
      int s;
      s = order[pos];
      for (int i = pos; i > 0; i--) order[i] = order[i - 1];
      order[0] = s;
    endfunction

    function void note_request(logic [1:0] cmd, logic [OFF_W-1:0] off, logic pe);
      cache_res_t r;
      logic [TAG_W-1:0] tag;
      int s, cap, n;
      r = '0;
      if (cmd == 2'd3) return;
      if (cmd == CMD_FLUSH) begin
        n = 0;
        for (int p = 0; p < count; p++) begin
          s = order[p];
          if (valid[s] && dirty[s]) begin
            r = '0;
            r.writeback = 1;
            r.wb_block = tags[s];
            r.wb_slot = SLOT_W'(s);
            pending.push_back(r);
            n++;
          end
        end
        if (n > 0) pending[$].last = 1;
        clear_all();
        return;
      end
      tag = off[OFF_W-1:BLOCK_SHIFT];
      for (int p = 0; p < count; p++) begin
        s = order[p];
        if (valid[s] && tags[s] == tag) begin
          move_to_head(p);
          if (cmd == CMD_WRITE) dirty[s] = 1;
          r.hit = 1;
          r.slot = SLOT_W'(s);
          r.last = 1;
          pending.push_back(r);
          return;
        end
      end
      cap = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES ? ENTRIES : cap_reg);
      // Most recently used block is the victim.
      if (count >= cap && count > 0) begin
        s = order[0];
        if (dirty[s]) begin
          r.writeback = 1;
          r.wb_block = tags[s];
          r.wb_slot = SLOT_W'(s);
        end
        for (int p = 0; p + 1 < count; p++) order[p] = order[p + 1];
        order[count - 1] = s;
        valid[s] = 0;
        dirty[s] = 0;
        count--;
      end
      r.fill = 1;
      r.last = 1;
      if (!(cmd == CMD_READ && pe)) begin
        s = order[count];
        move_to_head(count);
        tags[s] = tag;
        valid[s] = 1;
        dirty[s] = (cmd == CMD_WRITE);
        count++;
        r.slot = SLOT_W'(s);
        r.inserted = 1;
      end
      pending.push_back(r);
    endfunction

    function void check_result(cache_res_t got);
      cache_res_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [OFF_W-1:0] in_file_offset = '0;
  logic in_past_end = 0;
  logic out_valid, out_hit, out_fill, out_inserted, out_writeback, out_last;
  logic [SLOT_W-1:0] out_slot, out_writeback_slot;
  logic [TAG_W-1:0] out_writeback_block;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  cache_scoreboard sb;
  int sent;
  int burst_left;
  logic [TAG_W-1:0] hot_tags[8];

  always #6 clk = ~clk;

  mru_block_cache u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_file_offset(in_file_offset),
    .in_past_end(in_past_end), .out_valid(out_valid), .out_hit(out_hit),
    .out_slot(out_slot), .out_fill(out_fill), .out_inserted(out_inserted),
    .out_writeback(out_writeback), .out_writeback_block(out_writeback_block),
    .out_writeback_slot(out_writeback_slot), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_hit, out_slot, out_fill, out_inserted, out_writeback,
                       out_writeback_block, out_writeback_slot, out_last});
  end

  // Drives one request, after a random gap at the start of a burst, and holds start until the block takes it.
  task automatic send_request(logic [1:0] cmd, logic [OFF_W-1:0] off, logic pe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    in_command <= cmd;
    in_file_offset <= off;
    in_past_end <= pe;
    // Busy only changes at rising edges, so its value at the falling edge holds at the next one.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_request(cmd, off, pe);
    sent++;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 0;
    while (sb.pending.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    // Requests without a result may still be in progress.
    repeat (30) @(posedge clk);
  endtask

  task automatic write_capacity(int v);
    wait_idle();
    cfg_valid <= 1;
    cfg_data <= CNT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [OFF_W-1:0] rand_offset();
    return OFF_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [OFF_W-1:0] hot_offset();
    return {hot_tags[$urandom_range(0, 7)], 12'($urandom())};
  endfunction

  task automatic random_phase(int n);
    int k;
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 4) cmd = 2'd3;
      else if (k < 8) cmd = CMD_FLUSH;
      else cmd = (k < 55) ? CMD_READ : CMD_WRITE;
      send_request(cmd, (k % 5 == 0) ? rand_offset() : hot_offset(),
                   ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    sb.set_capacity(16);
    sent = 0;
    burst_left = 0;
    for (int i = 0; i < 8; i++) hot_tags[i] = TAG_W'({$urandom(), $urandom()});
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, hits, misses, past end, ignored command, flushes.
    send_request(CMD_FLUSH, '0, 0);
    send_request(CMD_READ, '0, 0);
    send_request(CMD_WRITE, 40'h0000000FFF, 1);
    send_request(CMD_READ, '1, 0);
    send_request(CMD_WRITE, '1, 0);
    send_request(CMD_READ, 40'h1234567000, 1);
    send_request(2'd3, 40'h5555555555, 1);
    send_request(CMD_READ, 40'hAAAAAAAAAA, 0);
    send_request(CMD_FLUSH, 40'h5555555555, 1);
    send_request(CMD_READ, '1, 0);
    send_request(CMD_FLUSH, '0, 0);
    write_capacity(1);
    send_request(CMD_WRITE, 40'h0000001000, 0);
    send_request(CMD_WRITE, 40'h0000002000, 0);
    send_request(CMD_READ, 40'h0000003000, 1);
    send_request(CMD_READ, 40'h0000004000, 0);
    write_capacity(0);
    send_request(CMD_WRITE, 40'h0000005000, 0);
    send_request(CMD_WRITE, 40'h0000006000, 0);
    write_capacity(16);
    for (int i = 0; i < 17; i++) send_request(CMD_WRITE, 40'(i) << 12, 0);
    write_capacity(3);  // lowered below the valid count
    send_request(CMD_READ, 40'h0000100000, 0);
    send_request(CMD_FLUSH, '0, 0);

    write_capacity(31);
    random_phase(45);
    write_capacity(2);
    random_phase(30);
    write_capacity(16);
    random_phase(40);
    write_capacity(5);
    random_phase(25);
    send_request(CMD_FLUSH, '0, 0);

    wait_idle();
    $display("Sent %0d requests over several capacity settings; %0d results checked.",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/mbc_pkg.sv
rtl/mbc_ctrl.sv
rtl/mbc_dp.sv
rtl/mru_block_cache.sv
tb/tb.sv
